### hdl/tfl_pkg.sv
// tfl_pkg: shared widths, latencies, status codes and types for the
// triangle_from_three_lines pipeline. No dependencies.
`default_nettype none

package tfl_pkg;

   // Fixed result widths
   localparam int VTX_W  = 32;
   localparam int SIDE_W = 34;
   localparam int AREA_W = 64;
   localparam int STAT_W = 3;

   // Quotient bits per divide and root bits per square root
   localparam int QBITS  = 32;
   localparam int ROOT_W = 33;
   localparam int RAD_W  = 2 * ROOT_W;

   // Stage counts of each section
   localparam int CRAMER_LAT  = 2;
   localparam int DIV_LAT     = QBITS + 3;
   localparam int SIDE_LAT    = ROOT_W + 4;
   localparam int AREA_STAGES = 5;

   // Clamp values for a Q16.16 coordinate
   localparam logic [VTX_W-1:0] VTX_MAX = {1'b0, {(VTX_W-1){1'b1}}};
   localparam logic [VTX_W-1:0] VTX_MIN = {1'b1, {(VTX_W-1){1'b0}}};

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_PAR12 = 3'd1,
      ST_PAR23 = 3'd2,
      ST_PAR13 = 3'd3,
      ST_SAT   = 3'd4
   } status_type;

   // Zero-determinant flags, one per line pair
   typedef struct packed {
      logic p12;
      logic p32;
      logic p13;
   } par_type;

endpackage

`default_nettype wire

### hdl/tfl_delay.sv
// tfl_delay: plain enable-gated shift line used to keep side data aligned
// with the arithmetic stages. No package dependencies.
`default_nettype none

module tfl_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   // Shift one place per advancing cycle
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule

`default_nettype wire

### hdl/tfl_cramer.sv
// tfl_cramer: two-stage determinant front end (products, then differences)
// for the three line pairs. Depends on tfl_pkg.
`default_nettype none

module tfl_cramer #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COEF_WIDTH-1:0]  coef [9],
   output logic signed [2*COEF_WIDTH:0]  det [3],
   output logic signed [2*COEF_WIDTH:0]  num_x [3],
   output logic signed [2*COEF_WIDTH:0]  num_y [3],
   output tfl_pkg::par_type              par
);
   import tfl_pkg::*;

   localparam int PW = 2 * COEF_WIDTH;
   localparam int DW = PW + 1;

   logic signed [PW-1:0] m_ff [3][6];
   logic signed [DW-1:0] det_ff [3];
   logic signed [DW-1:0] nx_ff [3];
   logic signed [DW-1:0] ny_ff [3];
   logic [2:0]           zero_ff;

   // Vertex a = lines 1,2; b = lines 3,2; c = lines 1,3
   for (genvar v = 0; v < 3; v++) begin : g_vtx
      localparam int P = (v == 1) ? 6 : 0;
      localparam int Q = (v == 2) ? 6 : 3;
      logic signed [DW-1:0] det_in;

      // products
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[v][0] <= coef[P]   * coef[Q+1];
            m_ff[v][1] <= coef[Q]   * coef[P+1];
            m_ff[v][2] <= coef[P+2] * coef[Q+1];
            m_ff[v][3] <= coef[P+1] * coef[Q+2];
            m_ff[v][4] <= coef[P]   * coef[Q+2];
            m_ff[v][5] <= coef[Q]   * coef[P+2];
         end
      end

      assign det_in = DW'(m_ff[v][0]) - DW'(m_ff[v][1]);

      // differences and parallel test
      always_ff @(posedge clock) begin
         if (en) begin
            det_ff[v]  <= det_in;
            nx_ff[v]   <= DW'(m_ff[v][2]) - DW'(m_ff[v][3]);
            ny_ff[v]   <= DW'(m_ff[v][4]) - DW'(m_ff[v][5]);
            zero_ff[v] <= (det_in == '0);
         end
      end

      assign det[v]   = det_ff[v];
      assign num_x[v] = nx_ff[v];
      assign num_y[v] = ny_ff[v];
   end

   assign par.p12 = zero_ff[0];
   assign par.p32 = zero_ff[1];
   assign par.p13 = zero_ff[2];

endmodule

`default_nettype wire

### hdl/tfl_fixdiv.sv
// tfl_fixdiv: pipelined restoring divider, num * 2^FRAC_BITS / den truncated
// toward zero and clamped to Q16.16, one quotient bit per stage. Uses tfl_pkg.
`default_nettype none

module tfl_fixdiv #(
   parameter int NUM_W     = 33,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [NUM_W-1:0]           num,
   input  logic signed [NUM_W-1:0]           den,
   output logic signed [tfl_pkg::VTX_W-1:0]  quot,
   output logic                              over
);
   import tfl_pkg::*;

   localparam int HW = NUM_W + FRAC_BITS;
   localparam int XW = HW + QBITS;

   logic [NUM_W-1:0] n_raw, d_raw, mag_n_in, mag_d_in;
   logic [NUM_W-1:0] mag_n_ff, mag_d_ff;
   logic             sgn_ff;

   // Stage A: magnitudes and result sign
   assign n_raw    = num;
   assign d_raw    = den;
   assign mag_n_in = n_raw[NUM_W-1] ? (~n_raw + 1'b1) : n_raw;
   assign mag_d_in = d_raw[NUM_W-1] ? (~d_raw + 1'b1) : d_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_n_ff <= mag_n_in;
         mag_d_ff <= mag_d_in;
         sgn_ff   <= n_raw[NUM_W-1] ^ d_raw[NUM_W-1];
      end
   end

   // Stage B: scale, early overflow (quotient needs more than QBITS bits)
   logic [XW-1:0]    scaled;
   logic [HW-1:0]    hi;
   logic [NUM_W-1:0] rem_ff [QBITS];
   logic [QBITS-1:0] low_ff [QBITS];
   logic [NUM_W-1:0] d_ff [QBITS];
   logic [QBITS-1:0] q_ff [QBITS+1];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];

   assign scaled = XW'(mag_n_ff) << FRAC_BITS;
   assign hi     = scaled[XW-1:QBITS];

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= (hi >= HW'(mag_d_ff));
         rem_ff[0] <= hi[NUM_W-1:0];
         low_ff[0] <= scaled[QBITS-1:0];
         d_ff[0]   <= mag_d_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= sgn_ff;
      end
   end

   // One compare-subtract per stage
   for (genvar k = 0; k < QBITS; k++) begin : g_step
      logic [NUM_W:0] rsh, diff;
      logic           ge;

      assign rsh  = {rem_ff[k], low_ff[k][QBITS-1]};
      assign diff = rsh - {1'b0, d_ff[k]};
      assign ge   = (rsh >= {1'b0, d_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1]   <= {q_ff[k][QBITS-2:0], ge};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end

      if (k < QBITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge ? diff[NUM_W-1:0] : rsh[NUM_W-1:0];
               low_ff[k+1] <= low_ff[k] << 1;
               d_ff[k+1]   <= d_ff[k];
            end
         end
      end
   end

   // Final stage: clamp and apply sign
   logic [QBITS-1:0] qf;
   logic             over_in;
   logic [VTX_W-1:0] quot_in;
   logic [VTX_W-1:0] quot_ff;
   logic             over_ff;

   assign qf      = q_ff[QBITS];
   assign over_in = ovf_ff[QBITS] ||
                    (qf[QBITS-1] && ((|qf[QBITS-2:0]) || !neg_ff[QBITS]));

   always_comb begin
      if (over_in) begin
         quot_in = neg_ff[QBITS] ? VTX_MIN : VTX_MAX;
      end else if (neg_ff[QBITS]) begin
         quot_in = VTX_W'(-qf);
      end else begin
         quot_in = VTX_W'(qf);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
         over_ff <= over_in;
      end
   end

   assign quot = quot_ff;
   assign over = over_ff;

endmodule

`default_nettype wire

### hdl/tfl_side.sv
// tfl_side: distance between two Q16.16 points: difference, magnitude,
// squares, sum, then a pipelined digit-by-digit square root. Uses tfl_pkg.
`default_nettype none

module tfl_side (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [tfl_pkg::VTX_W-1:0]  x1,
   input  logic signed [tfl_pkg::VTX_W-1:0]  y1,
   input  logic signed [tfl_pkg::VTX_W-1:0]  x2,
   input  logic signed [tfl_pkg::VTX_W-1:0]  y2,
   output logic [tfl_pkg::SIDE_W-1:0]        side
);
   import tfl_pkg::*;

   localparam int DIF_W = VTX_W + 1;
   localparam int SQ_W  = 2 * VTX_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int REM_W = ROOT_W + 1;
   localparam int RSH_W = REM_W + 2;

   logic signed [DIF_W-1:0] dx_ff, dy_ff;
   logic [VTX_W-1:0]        ax_ff, ay_ff;
   logic [SQ_W-1:0]         sx_ff, sy_ff;
   logic [SUM_W-1:0]        sum_ff;

   // Front end: difference, magnitude, square, sum
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= DIF_W'(x1) - DIF_W'(x2);
         dy_ff  <= DIF_W'(y1) - DIF_W'(y2);
         ax_ff  <= dx_ff[DIF_W-1] ? VTX_W'(-dx_ff) : VTX_W'(dx_ff);
         ay_ff  <= dy_ff[DIF_W-1] ? VTX_W'(-dy_ff) : VTX_W'(dy_ff);
         sx_ff  <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         sy_ff  <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         sum_ff <= SUM_W'(sx_ff) + SUM_W'(sy_ff);
      end
   end

   // Square root: two radicand bits and one root bit per stage
   logic [ROOT_W-1:0] root_src [ROOT_W];
   logic [REM_W-1:0]  rem_src [ROOT_W];
   logic [RAD_W-1:0]  rad_src [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff [ROOT_W-1];
   logic [RAD_W-1:0]  rad_ff [ROOT_W-1];

   assign root_src[0] = '0;
   assign rem_src[0]  = '0;
   assign rad_src[0]  = RAD_W'(sum_ff);

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      logic [RSH_W-1:0] rsh, trial;
      logic             ge;

      if (j > 0) begin : g_link
         assign root_src[j] = root_ff[j-1];
         assign rem_src[j]  = rem_ff[j-1];
         assign rad_src[j]  = rad_ff[j-1];
      end

      assign rsh   = {rem_src[j], rad_src[j][RAD_W-1 -: 2]};
      assign trial = RSH_W'({root_src[j], 2'b01});
      assign ge    = (rsh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= {root_src[j][ROOT_W-2:0], ge};
         end
      end

      if (j < ROOT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? REM_W'(rsh - trial) : REM_W'(rsh);
               rad_ff[j] <= rad_src[j] << 2;
            end
         end
      end
   end

   assign side = SIDE_W'(root_ff[ROOT_W-1]);

endmodule

`default_nettype wire

### hdl/tfl_area.sv
// tfl_area: signed shoelace area, half the sum truncated toward zero, padded
// to the side-length latency. Depends on tfl_pkg and tfl_delay.
`default_nettype none

module tfl_area #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [tfl_pkg::VTX_W-1:0]  xa,
   input  logic signed [tfl_pkg::VTX_W-1:0]  ya,
   input  logic signed [tfl_pkg::VTX_W-1:0]  xb,
   input  logic signed [tfl_pkg::VTX_W-1:0]  yb,
   input  logic signed [tfl_pkg::VTX_W-1:0]  xc,
   input  logic signed [tfl_pkg::VTX_W-1:0]  yc,
   output logic [tfl_pkg::AREA_W-1:0]        area
);
   import tfl_pkg::*;

   localparam int EW  = VTX_W + 1;
   localparam int TW  = VTX_W + EW;
   localparam int S2W = TW + 1;
   localparam int SW  = TW + 2;
   localparam int SH  = FRAC_BITS + 1;
   localparam logic [SW-1:0] BIAS = {{(SW-SH){1'b0}}, {SH{1'b1}}};

   logic signed [EW-1:0]    e_ff [3];
   logic signed [VTX_W-1:0] x_ff [3];
   logic signed [TW-1:0]    t_ff [3];
   logic signed [S2W-1:0]   s01_ff;
   logic signed [TW-1:0]    t2_ff;
   logic signed [SW-1:0]    s_ff;
   logic signed [SW-1:0]    biased;
   logic [AREA_W-1:0]       area_ff;

   // Coordinate differences, products, then a two-step sum
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= EW'(yb) - EW'(yc);
         e_ff[1] <= EW'(yc) - EW'(ya);
         e_ff[2] <= EW'(ya) - EW'(yb);
         x_ff[0] <= xa;
         x_ff[1] <= xb;
         x_ff[2] <= xc;
         for (int i = 0; i < 3; i++) begin
            t_ff[i] <= TW'(x_ff[i]) * TW'(e_ff[i]);
         end
         s01_ff <= S2W'(t_ff[0]) + S2W'(t_ff[1]);
         t2_ff  <= t_ff[2];
         s_ff   <= SW'(s01_ff) + SW'(t2_ff);
      end
   end

   // Divide by 2^(FRAC_BITS+1), rounding toward zero
   assign biased = s_ff + (s_ff[SW-1] ? BIAS : '0);

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff <= AREA_W'(biased >>> SH);
      end
   end

   tfl_delay #(
      .WIDTH (AREA_W),
      .DEPTH (SIDE_LAT - AREA_STAGES)
   ) u_pad (
      .clock (clock),
      .en    (en),
      .din   (area_ff),
      .dout  (area)
   );

endmodule

`default_nettype wire

### hdl/triangle_from_three_lines.sv
// triangle_from_three_lines: vertices, side lengths and area of the triangle
// formed by three lines. Throughput one beat per cycle; the stages are 2 for
// the determinants, 35 for the 32-step dividers and 37 for the 33-step square
// roots, plus an output register. A stalled output beat holds the whole
// pipeline in place. Synchronous reset clears only the valid bits; payload is
// not reset.
`default_nettype none

module triangle_from_three_lines #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COEF_WIDTH-1:0]      req_line1_a,
   input  logic signed [COEF_WIDTH-1:0]      req_line1_b,
   input  logic signed [COEF_WIDTH-1:0]      req_line1_c,
   input  logic signed [COEF_WIDTH-1:0]      req_line2_a,
   input  logic signed [COEF_WIDTH-1:0]      req_line2_b,
   input  logic signed [COEF_WIDTH-1:0]      req_line2_c,
   input  logic signed [COEF_WIDTH-1:0]      req_line3_a,
   input  logic signed [COEF_WIDTH-1:0]      req_line3_b,
   input  logic signed [COEF_WIDTH-1:0]      req_line3_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_a_x,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_a_y,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_b_x,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_b_y,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_c_x,
   output logic signed [tfl_pkg::VTX_W-1:0]  rsp_vertex_c_y,
   output logic [tfl_pkg::SIDE_W-1:0]        rsp_side_ab,
   output logic [tfl_pkg::SIDE_W-1:0]        rsp_side_bc,
   output logic [tfl_pkg::SIDE_W-1:0]        rsp_side_ca,
   output logic signed [tfl_pkg::AREA_W-1:0] rsp_signed_area,
   output logic [tfl_pkg::STAT_W-1:0]        rsp_status
);
   import tfl_pkg::*;

   localparam int DW  = 2 * COEF_WIDTH + 1;
   localparam int LAT = CRAMER_LAT + DIV_LAT + SIDE_LAT + 1;
   localparam int VPW = 6 * VTX_W;

   // Global advance: the pipe moves unless the output beat is held
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Determinants and numerators
   logic signed [COEF_WIDTH-1:0] coef [9];
   logic signed [DW-1:0]         det [3];
   logic signed [DW-1:0]         num_x [3];
   logic signed [DW-1:0]         num_y [3];
   par_type                      par;

   assign coef[0] = req_line1_a;
   assign coef[1] = req_line1_b;
   assign coef[2] = req_line1_c;
   assign coef[3] = req_line2_a;
   assign coef[4] = req_line2_b;
   assign coef[5] = req_line2_c;
   assign coef[6] = req_line3_a;
   assign coef[7] = req_line3_b;
   assign coef[8] = req_line3_c;

   tfl_cramer #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_cramer (
      .clock (clock),
      .en    (adv),
      .coef  (coef),
      .det   (det),
      .num_x (num_x),
      .num_y (num_y),
      .par   (par)
   );

   // Six dividers, two per vertex
   logic signed [VTX_W-1:0] vx [3];
   logic signed [VTX_W-1:0] vy [3];
   logic [2:0]              ovx, ovy;

   for (genvar v = 0; v < 3; v++) begin : g_div
      tfl_fixdiv #(
         .NUM_W     (DW),
         .FRAC_BITS (FRAC_BITS)
      ) u_div_x (
         .clock (clock),
         .en    (adv),
         .num   (num_x[v]),
         .den   (det[v]),
         .quot  (vx[v]),
         .over  (ovx[v])
      );

      tfl_fixdiv #(
         .NUM_W     (DW),
         .FRAC_BITS (FRAC_BITS)
      ) u_div_y (
         .clock (clock),
         .en    (adv),
         .num   (num_y[v]),
         .den   (det[v]),
         .quot  (vy[v]),
         .over  (ovy[v])
      );
   end

   // Parallel flags ride alongside the dividers
   logic [$bits(par_type)-1:0] par_raw;
   par_type                    par_d;

   tfl_delay #(
      .WIDTH ($bits(par_type)),
      .DEPTH (DIV_LAT)
   ) u_par_dly (
      .clock (clock),
      .en    (adv),
      .din   (par),
      .dout  (par_raw)
   );

   assign par_d = par_type'(par_raw);

   // Status: first parallel pair wins, then saturation
   status_type status_in;

   always_comb begin
      priority if (par_d.p12) begin
         status_in = ST_PAR12;
      end else if (par_d.p32) begin
         status_in = ST_PAR23;
      end else if (par_d.p13) begin
         status_in = ST_PAR13;
      end else if ((|ovx) || (|ovy)) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   // Sides and area
   logic [SIDE_W-1:0] side_ab, side_bc, side_ca;
   logic [AREA_W-1:0] area;

   tfl_side u_side_ab (
      .clock (clock),
      .en    (adv),
      .x1    (vx[0]),
      .y1    (vy[0]),
      .x2    (vx[1]),
      .y2    (vy[1]),
      .side  (side_ab)
   );

   tfl_side u_side_bc (
      .clock (clock),
      .en    (adv),
      .x1    (vx[2]),
      .y1    (vy[2]),
      .x2    (vx[1]),
      .y2    (vy[1]),
      .side  (side_bc)
   );

   tfl_side u_side_ca (
      .clock (clock),
      .en    (adv),
      .x1    (vx[0]),
      .y1    (vy[0]),
      .x2    (vx[2]),
      .y2    (vy[2]),
      .side  (side_ca)
   );

   tfl_area #(
      .FRAC_BITS (FRAC_BITS)
   ) u_area (
      .clock (clock),
      .en    (adv),
      .xa    (vx[0]),
      .ya    (vy[0]),
      .xb    (vx[1]),
      .yb    (vy[1]),
      .xc    (vx[2]),
      .yc    (vy[2]),
      .area  (area)
   );

   // Vertices and status wait for the square roots
   logic [VPW-1:0]    vtx_pk, vtx_d;
   logic [STAT_W-1:0] status_raw;
   status_type        status_d;
   logic              par_out;

   assign vtx_pk = {vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]};

   tfl_delay #(
      .WIDTH (VPW),
      .DEPTH (SIDE_LAT)
   ) u_vtx_dly (
      .clock (clock),
      .en    (adv),
      .din   (vtx_pk),
      .dout  (vtx_d)
   );

   tfl_delay #(
      .WIDTH (STAT_W),
      .DEPTH (SIDE_LAT)
   ) u_stat_dly (
      .clock (clock),
      .en    (adv),
      .din   (status_in),
      .dout  (status_raw)
   );

   assign status_d = status_type'(status_raw);
   assign par_out  = (status_d == ST_PAR12) || (status_d == ST_PAR23) ||
                     (status_d == ST_PAR13);

   // Output register; a parallel pair zeroes every other field
   logic [VTX_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [SIDE_W-1:0] sab_ff, sbc_ff, sca_ff;
   logic [AREA_W-1:0] area_ff;
   status_type        status_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_d;
         if (par_out) begin
            ax_ff   <= '0;
            ay_ff   <= '0;
            bx_ff   <= '0;
            by_ff   <= '0;
            cx_ff   <= '0;
            cy_ff   <= '0;
            sab_ff  <= '0;
            sbc_ff  <= '0;
            sca_ff  <= '0;
            area_ff <= '0;
         end else begin
            ax_ff   <= vtx_d[6*VTX_W-1 -: VTX_W];
            ay_ff   <= vtx_d[5*VTX_W-1 -: VTX_W];
            bx_ff   <= vtx_d[4*VTX_W-1 -: VTX_W];
            by_ff   <= vtx_d[3*VTX_W-1 -: VTX_W];
            cx_ff   <= vtx_d[2*VTX_W-1 -: VTX_W];
            cy_ff   <= vtx_d[VTX_W-1 -: VTX_W];
            sab_ff  <= side_ab;
            sbc_ff  <= side_bc;
            sca_ff  <= side_ca;
            area_ff <= area;
         end
      end
   end

   assign rsp_vertex_a_x  = ax_ff;
   assign rsp_vertex_a_y  = ay_ff;
   assign rsp_vertex_b_x  = bx_ff;
   assign rsp_vertex_b_y  = by_ff;
   assign rsp_vertex_c_x  = cx_ff;
   assign rsp_vertex_c_y  = cy_ff;
   assign rsp_side_ab     = sab_ff;
   assign rsp_side_bc     = sbc_ff;
   assign rsp_side_ca     = sca_ff;
   assign rsp_signed_area = area_ff;
   assign rsp_status      = status_ff;

   // A parallel-pair beat carries no geometry
   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_PAR12) || (rsp_status == ST_PAR23) ||
                    (rsp_status == ST_PAR13))
      |-> (rsp_signed_area == '0) && (rsp_side_ab == '0) &&
          (rsp_vertex_a_x == '0) && (rsp_vertex_c_y == '0))
      else $error("parallel beat with nonzero geometry");

   // Only defined status codes leave the block
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_SAT))
      else $error("undefined status code");

   // A saturated beat has at least one clamped coordinate
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_SAT)
      |-> (rsp_vertex_a_x == VTX_MAX) || (rsp_vertex_a_x == VTX_MIN) ||
          (rsp_vertex_a_y == VTX_MAX) || (rsp_vertex_a_y == VTX_MIN) ||
          (rsp_vertex_b_x == VTX_MAX) || (rsp_vertex_b_x == VTX_MIN) ||
          (rsp_vertex_b_y == VTX_MAX) || (rsp_vertex_b_y == VTX_MIN) ||
          (rsp_vertex_c_x == VTX_MAX) || (rsp_vertex_c_x == VTX_MIN) ||
          (rsp_vertex_c_y == VTX_MAX) || (rsp_vertex_c_y == VTX_MIN))
      else $error("saturated beat without a clamped coordinate");

endmodule

`default_nettype wire
